// ===== rtl/cfe_pkg.sv =====
// ---------------------------------------------------------------------------
// cfe_pkg
// Shared types, constants and helper functions for the command frame
// encoder with CRC-16/MODBUS.
// ---------------------------------------------------------------------------
package cfe_pkg;

    // input action codes
    localparam logic [1:0] ACT_BEGIN   = 2'd0;
    localparam logic [1:0] ACT_PAYLOAD = 2'd1;
    localparam logic [1:0] ACT_FINISH  = 2'd2;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] LEN_EXTRA = 16'd2;
    localparam logic [7:0]  TRAIL_A   = 8'hDD;
    localparam logic [7:0]  TRAIL_B   = 8'hEE;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // byte index within a job, up to six bytes
    localparam int IDX_W = 3;

    typedef enum logic [1:0] {
        JOB_BEGIN,
        JOB_PAYLOAD,
        JOB_FINISH
    } job_kind_t;

    // begin:   data = {command, -}
    // payload: data = {byte, -}
    // finish:  data = {length, crc}
    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] data;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // index of the last byte of a job
    function automatic logic [IDX_W-1:0] last_index(input job_kind_t kind);
        logic [IDX_W-1:0] n;
        unique case (kind)
            JOB_BEGIN:   n = IDX_W'(1);
            JOB_PAYLOAD: n = IDX_W'(0);
            JOB_FINISH:  n = IDX_W'(5);
            default:     n = IDX_W'(0);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] job_byte(input job_t job, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            IDX_W'(0): b = job.data[31:24];
            IDX_W'(1): b = job.data[23:16];
            IDX_W'(2): b = job.data[15:8];
            IDX_W'(3): b = job.data[7:0];
            IDX_W'(4): b = TRAIL_A;
            IDX_W'(5): b = TRAIL_B;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/command_frame_encoder_crc16_unit.sv =====
// ---------------------------------------------------------------------------
// command_frame_encoder_crc16_unit
// Serial command frame encoder with CRC-16/MODBUS (init 0xFFFF, poly 0xA001).
// ---------------------------------------------------------------------------
// A begin item sends the command bytes, a payload item its byte, and a finish
// item sends length (payload count plus 2), CRC, 0xDD and 0xEE with frame_end
// on the last byte. Items are taken one per cycle while the four-entry job
// queue has room; the byte sequencer sends one frame byte per cycle while the
// output is drained, so a begin item gives two bytes, a payload item one and a
// finish item six. The first byte of an item passes through the job queue, the
// current job register and the output register on its way to tx_byte.
module command_frame_encoder_crc16_unit
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [15:0] command,
    input  logic [7:0]  payload_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  tx_byte,
    output logic        frame_end
);

    logic accept;
    logic job_push;
    job_t job;
    job_t q_job;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    cfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .command      (command),
        .payload_byte (payload_byte),
        .job_push     (job_push),
        .job          (job)
    );

    cfe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job),
        .full   (full),
        .rd_en  (q_pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    cfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .tx_byte   (tx_byte),
        .frame_end (frame_end)
    );

endmodule

// ===== rtl/cfe_front.sv =====
// ---------------------------------------------------------------------------
// cfe_front
// Accepts input transactions, keeps the running CRC and payload count and
// turns each begin, payload or finish item into a job for the byte sequencer.
// ---------------------------------------------------------------------------
module cfe_front
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  action,
    input  logic [15:0] command,
    input  logic [7:0]  payload_byte,
    output logic        job_push,
    output job_t        job
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] crc_mid;
    logic [15:0] crc_end;
    logic [15:0] frame_len;

    assign frame_len = count_reg + LEN_EXTRA;

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        job_push   = 1'b0;
        job.kind   = JOB_PAYLOAD;
        job.data   = 32'h0;
        crc_mid    = 16'h0;
        crc_end    = 16'h0;
        unique case (action)
            ACT_BEGIN:
            begin
                crc_mid    = crc_byte(CRC_INIT, command[15:8]);
                crc_end    = crc_byte(crc_mid, command[7:0]);
                crc_next   = crc_end;
                count_next = 16'h0;
                job_push   = accept;
                job.kind   = JOB_BEGIN;
                job.data   = {command, 16'h0};
            end
            ACT_PAYLOAD:
            begin
                crc_next   = crc_byte(crc_reg, payload_byte);
                count_next = count_reg + 16'd1;
                job_push   = accept;
                job.kind   = JOB_PAYLOAD;
                job.data   = {payload_byte, 24'h0};
            end
            ACT_FINISH:
            begin
                crc_mid    = crc_byte(crc_reg, frame_len[15:8]);
                crc_end    = crc_byte(crc_mid, frame_len[7:0]);
                crc_next   = CRC_INIT;
                count_next = 16'h0;
                job_push   = accept;
                job.kind   = JOB_FINISH;
                job.data   = {frame_len, crc_end};
            end
            default:
            begin
                // unused code: no bytes, state kept
                job_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= 16'h0;
        end
        else if (accept)
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/cfe_queue.sv =====
// ---------------------------------------------------------------------------
// cfe_queue
// Short job queue that decouples the front end from the byte sequencer.
// ---------------------------------------------------------------------------
module cfe_queue
    import cfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    job_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == QCNT_W'(0));
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = queue_mem[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0) : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            queue_mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/cfe_back.sv =====
// ---------------------------------------------------------------------------
// cfe_back
// Byte sequencer: takes jobs from the queue and sends their frame bytes
// one per cycle into the output register while it is empty or being popped.
// ---------------------------------------------------------------------------
module cfe_back
    import cfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] tx_byte,
    output logic       frame_end
);

    logic             cur_valid_reg;
    job_t             cur_job_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;
    logic             out_free;
    logic             advance;
    logic             last;

    assign out_free  = !out_valid_reg || pop;
    assign advance   = cur_valid_reg && out_free;
    assign last      = (idx_reg == last_index(cur_job_reg.kind));
    // refill the current job when idle or when its last byte leaves
    assign q_pop     = !q_empty && (!cur_valid_reg || (advance && last));
    assign empty     = !out_valid_reg;
    assign tx_byte   = out_byte_reg;
    assign frame_end = out_end_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_job_reg <= q_job;
        end
        if (advance)
        begin
            out_byte_reg <= job_byte(cur_job_reg, idx_reg);
            out_end_reg  <= (cur_job_reg.kind == JOB_FINISH) && last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (advance)
            begin
                if (last)
                begin
                    cur_valid_reg <= 1'b0;
                    idx_reg       <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of command_frame_encoder_crc16_unit. Items go in through
// the push/full side, and each frame byte that comes out through empty/pop is
// compared with a byte predicted by a CRC-16/MODBUS frame builder kept in this
// file. Directed frames come first, then backpressure and drain pauses, and
// random frames mixed with noise, one of them with a long payload.
// ----------------------------------------------------------------------------
module testbench
    import cfe_pkg::*;
();

    localparam logic [1:0]  ACT_UNUSED     = 2'd3;
    localparam logic [15:0] MODBUS_SEED    = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY    = 16'hA001;
    localparam logic [15:0] FRAME_LEN_BIAS = 16'd2;
    localparam logic [7:0]  TRAILER_FIRST  = 8'hDD;
    localparam logic [7:0]  TRAILER_LAST   = 8'hEE;
    localparam int MAX_GAP       = 14;
    localparam int HOLD_CYCLES   = 120;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_ITEMS  = 320;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [1:0]  action = 2'd0;
    logic [15:0] command = 16'd0;
    logic [7:0]  payload_byte = 8'd0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  tx_byte;
    logic        frame_end;

    // frame builder state
    logic [15:0] frame_crc = MODBUS_SEED;
    logic [15:0] frame_payload_count = 16'd0;
    frame_byte_t pending_bytes[$];

    bit sender_gaps_on = 1'b1;
    bit receiver_gaps_on = 1'b1;
    bit hold_output = 1'b0;

    int error_count = 0;
    int items_taken = 0;
    int frames_closed = 0;
    int bytes_checked = 0;
    int input_stall_cycles = 0;
    int idle_cycles = 0;

    command_frame_encoder_crc16_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .command      (command),
        .payload_byte (payload_byte),
        .empty        (empty),
        .pop          (pop),
        .tx_byte      (tx_byte),
        .frame_end    (frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bit-serial reflected crc, lsb of the data byte first
    function automatic logic [15:0] modbus_crc_step(logic [15:0] crc, logic [7:0] data);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ data[i])
                r = {1'b0, r[15:1]} ^ MODBUS_POLY;
            else
                r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    function automatic void expect_byte(logic [7:0] data, logic last);
        frame_byte_t b;
        b.data = data;
        b.last = last;
        pending_bytes.push_back(b);
    endfunction

    function automatic void predict_frame_bytes(logic [1:0] act, logic [15:0] cmd,
                                                logic [7:0] data);
        logic [15:0] frame_len;
        logic [15:0] crc_out;
        case (act)
            ACT_BEGIN:
            begin
                // a begin drops whatever frame was open
                frame_crc = modbus_crc_step(modbus_crc_step(MODBUS_SEED, cmd[15:8]), cmd[7:0]);
                frame_payload_count = 16'd0;
                expect_byte(cmd[15:8], 1'b0);
                expect_byte(cmd[7:0], 1'b0);
            end
            ACT_PAYLOAD:
            begin
                frame_crc = modbus_crc_step(frame_crc, data);
                frame_payload_count = frame_payload_count + 16'd1;
                expect_byte(data, 1'b0);
            end
            ACT_FINISH:
            begin
                frame_len = frame_payload_count + FRAME_LEN_BIAS;
                crc_out = modbus_crc_step(modbus_crc_step(frame_crc, frame_len[15:8]),
                                          frame_len[7:0]);
                expect_byte(frame_len[15:8], 1'b0);
                expect_byte(frame_len[7:0], 1'b0);
                expect_byte(crc_out[15:8], 1'b0);
                expect_byte(crc_out[7:0], 1'b0);
                expect_byte(TRAILER_FIRST, 1'b0);
                expect_byte(TRAILER_LAST, 1'b1);
                frame_crc = MODBUS_SEED;
                frame_payload_count = 16'd0;
                frames_closed++;
            end
            default:
            begin
                // unused code: nothing comes out, nothing changes
            end
        endcase
    endfunction

    function automatic void report_mismatch(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void check_frame_byte(logic [7:0] got_byte, logic got_end);
        frame_byte_t want;
        bytes_checked++;
        if (pending_bytes.size() == 0)
        begin
            report_mismatch($sformatf("byte %0d: nothing expected, got tx_byte %02h frame_end %0b",
                                      bytes_checked, got_byte, got_end));
        end
        else
        begin
            want = pending_bytes.pop_front();
            if (want.data !== got_byte || want.last !== got_end)
                report_mismatch($sformatf(
                    "byte %0d: expected tx_byte %02h frame_end %0b, got %02h %0b",
                    bytes_checked, want.data, want.last, got_byte, got_end));
        end
    endfunction

    // push stays high after a transaction so back-to-back items need no toggle
    task automatic send_item(logic [1:0] act, logic [15:0] cmd, logic [7:0] data);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        action <= act;
        command <= cmd;
        payload_byte <= data;
        do
            @(posedge clk);
        while (full);
        predict_frame_bytes(act, cmd, data);
        if (act != ACT_UNUSED)
            items_taken++;
    endtask

    // only called right after a transaction, so push gets one assignment per step
    task automatic rest_sender();
        push <= 1'b0;
    endtask

    // waits on the clock before it checks, so the next item is driven in a later step
    task automatic wait_for_drain();
        rest_sender();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    task automatic test_directed_frames();
        // finish and payload with no begin work on the reset state
        send_item(ACT_FINISH, 16'hFFFF, 8'hFF);
        send_item(ACT_PAYLOAD, 16'h0000, 8'h00);
        send_item(ACT_PAYLOAD, 16'hFFFF, 8'hFF);
        send_item(ACT_FINISH, 16'h0000, 8'h00);
        // empty payload, extreme commands
        send_item(ACT_BEGIN, 16'h0000, 8'hFF);
        send_item(ACT_FINISH, 16'hFFFF, 8'h00);
        send_item(ACT_BEGIN, 16'hFFFF, 8'h00);
        send_item(ACT_PAYLOAD, 16'h0000, 8'h80);
        send_item(ACT_UNUSED, 16'hFFFF, 8'hFF);
        send_item(ACT_PAYLOAD, 16'hFFFF, 8'h01);
        send_item(ACT_FINISH, 16'h5555, 8'hAA);
        // begin in the middle of a frame restarts it
        send_item(ACT_BEGIN, 16'hA5C3, 8'h00);
        send_item(ACT_PAYLOAD, 16'h0000, 8'h55);
        send_item(ACT_BEGIN, 16'h1234, 8'h00);
        send_item(ACT_PAYLOAD, 16'h0000, 8'hAA);
        send_item(ACT_FINISH, 16'h0000, 8'h00);
        send_item(ACT_UNUSED, 16'h0000, 8'h00);
        send_item(ACT_BEGIN, 16'h8001, 8'h7F);
        send_item(ACT_PAYLOAD, 16'h7FFE, 8'h7F);
        send_item(ACT_FINISH, 16'h8001, 8'h80);
    endtask

    task automatic send_random_frame(int payload_len);
        send_item(ACT_BEGIN, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        for (int i = 0; i < payload_len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(ACT_UNUSED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            send_item(ACT_PAYLOAD, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
        send_item(ACT_FINISH, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    endtask

    // sink held off while the source keeps pushing back to back
    task automatic test_output_backpressure();
        sender_gaps_on = 1'b0;
        hold_output = 1'b1;
        send_random_frame(30);
        send_random_frame(4);
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_item(ACT_BEGIN, 16'h3C3C, 8'h00);
        send_item(ACT_PAYLOAD, 16'h0000, 8'h5A);
        send_item(ACT_PAYLOAD, 16'h0000, 8'hC3);
        wait_for_drain();
        send_item(ACT_PAYLOAD, 16'h0000, 8'h0F);
        send_item(ACT_FINISH, 16'h0000, 8'h00);
        wait_for_drain();
        send_item(ACT_FINISH, 16'h0000, 8'h00);
    endtask

    task automatic test_random_frames();
        int stop_at;
        int pick;
        stop_at = items_taken + RANDOM_ITEMS;
        // payload of 248 to 260 bytes, around the limit of an 8-bit byte counter
        send_random_frame($urandom_range(248, 260));
        while (items_taken < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                sender_gaps_on = ($urandom_range(0, 2) != 0);
                receiver_gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (pick < 15)
                send_random_frame($urandom_range(0, 12));
            else if (pick == 15)
                send_random_frame($urandom_range(13, 30));
            else if (pick == 16)
                wait_for_drain();
            else
            begin
                // noise: loose items of any kind, frames left open
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)));
            end
        end
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_output)
            begin
                stall = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            else
            begin
                stall = receiver_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_frame_byte(tx_byte, frame_end);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && full)
                input_stall_cycles++;
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("FAIL command_frame_encoder_crc16_unit");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_output_backpressure();
        test_sender_pause();
        test_random_frames();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came out",
                                      pending_bytes.size()));
        $display("covered %0d items, %0d closed frames, %0d bytes checked",
                 items_taken, frames_closed, bytes_checked);
        $display("input held by full for %0d cycles, %0d mismatches",
                 input_stall_cycles, error_count);
        if (error_count == 0)
            $display("PASS command_frame_encoder_crc16_unit");
        else
            $display("FAIL command_frame_encoder_crc16_unit");
        $finish;
    end

endmodule
